// ===== src/intercore_mailbox_interrupt_unit_macros.svh =====
// assertion helpers for the inter-core mailbox and interrupt unit
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef INTERCORE_MAILBOX_INTERRUPT_UNIT_MACROS_SVH
`define INTERCORE_MAILBOX_INTERRUPT_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define IMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/imu_pkg.sv =====
// shared types and constants of the inter-core mailbox and interrupt unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package imu_pkg;

  localparam int unsigned MailboxDepthDefault = 32;
  localparam int unsigned LineCountDefault    = 32;
  localparam int unsigned LockCountDefault    = 4;

  localparam int unsigned OffsetW = 10;
  localparam int unsigned DataW   = 32;

  // region bases in words
  localparam logic [OffsetW-1:0] MboxBase = 10'd256;
  localparam logic [OffsetW-1:0] IrqBase  = 10'd512;
  localparam logic [OffsetW-1:0] IrqLast  = 10'd520;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_e;

  // interrupt register words, relative to IrqBase
  typedef enum logic [3:0] {
    IRQ_RAW         = 4'd0,
    IRQ_SET         = 4'd1,
    IRQ_CLR         = 4'd2,
    IRQ_RISC_MASK   = 4'd3,
    IRQ_DSP_MASK    = 4'd4,
    IRQ_MCU_MASK    = 4'd5,
    IRQ_RISC_STATUS = 4'd6,
    IRQ_DSP_STATUS  = 4'd7,
    IRQ_MCU_STATUS  = 4'd8
  } irq_reg_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [OffsetW-1:0] word_offset;
    logic [DataW-1:0]   write_data;
  } imu_req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             access_error;
    logic             mcu_irq;
    logic             risc_irq;
    logic             dsp_irq;
  } imu_rsp_t;

endpackage

`default_nettype wire

// ===== src/intercore_mailbox_interrupt_unit.sv =====
// inter-core mailbox with hardware mutexes and soft-interrupt lines
// top level; uses imu_pkg and intercore_mailbox_interrupt_unit_macros.svh
//
// usage: one bus access per transaction on the request channel (req_valid_i,
// req_ready_o, req_i) and one response per access on the response channel
// (rsp_valid_o, rsp_ready_i, rsp_o). Mutex words start at offset 0, the
// mailbox at 256 and the interrupt registers at 512. A mutex read returns the
// old flag and takes it; writing 0 frees it.
// flow: a request taken lands in the input register, and its response is
// loaded into the output register once the response there is free or being
// taken, so a low rsp_ready_i can delay it. Throughput: one access per cycle
// while rsp_ready_i is high, set by the single decode and update stage between
// the two registers; the mailbox read port is fetched as the request is taken,
// with a bypass from a write in flight to the same word.
// reset: all mutexes free, no lines pending, every line masked for every core,
// mailbox words read as 0 until written.
// stall: while rsp_ready_i is low the response holds; one more request can
// wait in the input register, then req_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none
`include "intercore_mailbox_interrupt_unit_macros.svh"

module intercore_mailbox_interrupt_unit #(
  parameter int unsigned MailboxDepth = imu_pkg::MailboxDepthDefault,
  parameter int unsigned LineCount    = imu_pkg::LineCountDefault,
  parameter int unsigned LockCount    = imu_pkg::LockCountDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire imu_pkg::imu_req_t req_i,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output imu_pkg::imu_rsp_t     rsp_o
);

  localparam int unsigned MbIdxW   = (MailboxDepth > 1) ? $clog2(MailboxDepth) : 1;
  localparam int unsigned LockIdxW = (LockCount > 1) ? $clog2(LockCount) : 1;
  localparam logic [imu_pkg::DataW-1:0] LineMask =
      (LineCount >= 32) ? {imu_pkg::DataW{1'b1}}
                        : ((32'd1 << LineCount) - 32'd1);
  localparam logic [imu_pkg::OffsetW-1:0] LockEnd = imu_pkg::OffsetW'(LockCount);
  localparam logic [imu_pkg::OffsetW-1:0] MboxEnd =
      imu_pkg::MboxBase + imu_pkg::OffsetW'(MailboxDepth);

  // pipeline control
  imu_pkg::imu_req_t s1_q;
  logic              s1_vld_q;
  imu_pkg::imu_rsp_t rsp_q;
  imu_pkg::imu_rsp_t rsp_d;
  logic              rsp_vld_q;
  logic              req_acc;
  logic              s1_adv;

  // architectural state
  logic [imu_pkg::DataW-1:0] pend_q, pend_d;
  logic [imu_pkg::DataW-1:0] risc_mask_q, risc_mask_d;
  logic [imu_pkg::DataW-1:0] dsp_mask_q, dsp_mask_d;
  logic [imu_pkg::DataW-1:0] mcu_mask_q, mcu_mask_d;
  logic [LockCount-1:0]      lock_q, lock_d;

  // mailbox storage and its prefetch
  logic [imu_pkg::DataW-1:0] mbox_mem [MailboxDepth];
  logic [MailboxDepth-1:0]   mbox_vld_q;
  logic [imu_pkg::DataW-1:0] mbox_raw_q;
  logic [imu_pkg::DataW-1:0] fwd_data_q;
  logic                      fwd_q;
  logic                      hit_q;
  logic [MbIdxW-1:0]         mbox_ridx;
  logic [MbIdxW-1:0]         mbox_widx;
  logic                      mbox_we;
  logic                      fwd_d;
  logic [imu_pkg::DataW-1:0] mbox_word;

  // decode of the access in the input register
  logic                        wr;
  logic [imu_pkg::OffsetW-1:0] off;
  logic [imu_pkg::OffsetW-1:0] irq_rel;
  imu_pkg::irq_reg_e           irq_sel;
  logic                        is_lock;
  logic                        is_mbox;
  logic                        is_irq;
  logic [LockIdxW-1:0]         lock_idx;
  logic [imu_pkg::DataW-1:0]   rd;
  logic                        err;

  assign s1_adv      = s1_vld_q && (!rsp_vld_q || rsp_ready_i);
  assign req_ready_o = !s1_vld_q || s1_adv;
  assign req_acc     = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  assign wr       = (s1_q.req_type == imu_pkg::REQ_WRITE);
  assign off      = s1_q.word_offset;
  assign irq_rel  = off - imu_pkg::IrqBase;
  assign irq_sel  = imu_pkg::irq_reg_e'(irq_rel[3:0]);
  assign is_lock  = (off < LockEnd);
  assign is_mbox  = (off >= imu_pkg::MboxBase) && (off < MboxEnd);
  assign is_irq   = (off >= imu_pkg::IrqBase) && (off <= imu_pkg::IrqLast);
  assign lock_idx = off[LockIdxW-1:0];

  assign mbox_widx = off[MbIdxW-1:0];
  assign mbox_ridx = req_i.word_offset[MbIdxW-1:0];
  assign mbox_we   = s1_adv && is_mbox && wr;
  // write leaving the input register at the same edge as the fetch
  assign fwd_d     = mbox_we && (mbox_widx == mbox_ridx);
  assign mbox_word = fwd_q ? fwd_data_q : (hit_q ? mbox_raw_q : '0);

  always_comb begin
    pend_d      = pend_q;
    risc_mask_d = risc_mask_q;
    dsp_mask_d  = dsp_mask_q;
    mcu_mask_d  = mcu_mask_q;
    lock_d      = lock_q;
    rd          = '0;
    err         = 1'b0;
    priority if (is_lock) begin
      if (wr) begin
        if (s1_q.write_data == '0) lock_d[lock_idx] = 1'b0;
      end else begin
        rd               = {{(imu_pkg::DataW-1){1'b0}}, lock_q[lock_idx]};
        lock_d[lock_idx] = 1'b1;
      end
    end else if (is_mbox) begin
      if (!wr) rd = mbox_word;
    end else if (is_irq) begin
      unique case (irq_sel)
        imu_pkg::IRQ_RAW: begin
          if (!wr) rd = pend_q;
        end
        imu_pkg::IRQ_SET: begin
          if (wr) pend_d = pend_q | (s1_q.write_data & LineMask);
        end
        imu_pkg::IRQ_CLR: begin
          if (wr) pend_d = pend_q & ~s1_q.write_data;
        end
        imu_pkg::IRQ_RISC_MASK: begin
          if (wr) risc_mask_d = s1_q.write_data;
          else rd = risc_mask_q;
        end
        imu_pkg::IRQ_DSP_MASK: begin
          if (wr) dsp_mask_d = s1_q.write_data;
          else rd = dsp_mask_q;
        end
        imu_pkg::IRQ_MCU_MASK: begin
          if (wr) mcu_mask_d = s1_q.write_data;
          else rd = mcu_mask_q;
        end
        imu_pkg::IRQ_RISC_STATUS: begin
          if (!wr) rd = pend_q & ~risc_mask_q;
        end
        imu_pkg::IRQ_DSP_STATUS: begin
          if (!wr) rd = pend_q & ~dsp_mask_q;
        end
        imu_pkg::IRQ_MCU_STATUS: begin
          if (!wr) rd = pend_q & ~mcu_mask_q;
        end
        default: begin
        end
      endcase
    end else begin
      err = 1'b1;
    end
  end

  // interrupt levels follow the state after this access
  always_comb begin
    rsp_d.read_data    = rd;
    rsp_d.access_error = err;
    rsp_d.mcu_irq      = |(pend_d & ~mcu_mask_d);
    rsp_d.risc_irq     = |(pend_d & ~risc_mask_d);
    rsp_d.dsp_irq      = |(pend_d & ~dsp_mask_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      rsp_vld_q   <= 1'b0;
      pend_q      <= '0;
      risc_mask_q <= '1;
      dsp_mask_q  <= '1;
      mcu_mask_q  <= '1;
      lock_q      <= '0;
      mbox_vld_q  <= '0;
    end else begin
      if (req_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        rsp_vld_q   <= 1'b1;
        pend_q      <= pend_d;
        risc_mask_q <= risc_mask_d;
        dsp_mask_q  <= dsp_mask_d;
        mcu_mask_q  <= mcu_mask_d;
        lock_q      <= lock_d;
      end else if (rsp_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
      if (mbox_we) mbox_vld_q[mbox_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) s1_q <= req_i;
    if (s1_adv) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mbox_we) mbox_mem[mbox_widx] <= s1_q.write_data;
    if (req_acc) begin
      mbox_raw_q <= mbox_mem[mbox_ridx];
      hit_q      <= mbox_vld_q[mbox_ridx];
      fwd_q      <= fwd_d;
      fwd_data_q <= s1_q.write_data;
    end
  end

  `IMU_ASSERT_NEXT(a_lock_taken, s1_adv && is_lock && !wr, lock_q[$past(lock_idx)], "mutex read did not take the flag")
  `IMU_ASSERT_NEXT(a_err_zero, s1_adv && !is_lock && !is_mbox && !is_irq, rsp_o.access_error && (rsp_o.read_data == '0), "unmapped access gave data or no error")
  `IMU_ASSERT_NOW(a_line_range, 1'b1, (pend_q & ~LineMask) == '0, "pending line beyond line count")
  `IMU_ASSERT_NEXT(a_irq_level, s1_adv, rsp_o.mcu_irq == (|(pend_q & ~mcu_mask_q)), "mcu level does not match state")
  `IMU_ASSERT_NOW(a_full_stall, s1_vld_q && rsp_vld_q && !rsp_ready_i, !req_ready_o, "request taken while both stages are full")

endmodule

`default_nettype wire

// ===== bench/tb_intercore_mailbox_interrupt_unit.sv =====
// testbench for the inter-core mailbox and interrupt unit: directed and random bus accesses
// checked against a behavioural predictor; depends on imu_pkg and intercore_mailbox_interrupt_unit
`timescale 1ns / 1ps

module tb_intercore_mailbox_interrupt_unit;
  import imu_pkg::*;

  localparam int unsigned MailboxDepth = MailboxDepthDefault;
  localparam int unsigned LineCount    = LineCountDefault;
  localparam int unsigned LockCount    = LockCountDefault;
  localparam logic [DataW-1:0] LineMask =
    (LineCount >= 32) ? '1 : ((32'd1 << LineCount) - 32'd1);

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     req_valid_i = 1'b0;
  logic     req_ready_o;
  imu_req_t req_i       = '0;
  logic     rsp_valid_o;
  logic     rsp_ready_i = 1'b0;
  imu_rsp_t rsp_o;

  intercore_mailbox_interrupt_unit #(
    .MailboxDepth(MailboxDepth),
    .LineCount   (LineCount),
    .LockCount   (LockCount)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // predicted register state
  logic             lock_taken [LockCount];
  logic [DataW-1:0] mbox_mem [MailboxDepth];
  logic [DataW-1:0] raw_lines;
  logic [DataW-1:0] risc_mask;
  logic [DataW-1:0] dsp_mask;
  logic [DataW-1:0] mcu_mask;

  imu_rsp_t awaited_rsps[$];
  int       fail_count    = 0;
  int       send_idle_pct = 0;
  int       rsp_stall_pct = 0;
  int       hold_len      = 0;
  int       hold_seq      = 0;

  initial begin
    foreach (lock_taken[i]) lock_taken[i] = 1'b0;
    foreach (mbox_mem[i]) mbox_mem[i] = '0;
    raw_lines = '0;
    risc_mask = '1;
    dsp_mask  = '1;
    mcu_mask  = '1;
  end

  function automatic logic [OffsetW-1:0] irq_off(irq_reg_e sel);
    return IrqBase + OffsetW'(sel);
  endfunction

  function automatic bit is_mapped(logic [OffsetW-1:0] off);
    return (off < LockCount) || (off >= MboxBase && off < MboxBase + MailboxDepth) ||
           (off >= IrqBase && off <= IrqLast);
  endfunction

  // applies one access to the predicted state and returns its response
  function automatic imu_rsp_t apply_access(imu_req_t r);
    imu_rsp_t rsp;
    logic     wr;
    irq_reg_e sel;
    int       idx;
    rsp = '0;
    wr  = (r.req_type == REQ_WRITE);
    if (r.word_offset < LockCount) begin
      idx = int'(r.word_offset);
      if (wr) begin
        if (r.write_data == '0) lock_taken[idx] = 1'b0;
      end else begin
        rsp.read_data = DataW'(lock_taken[idx]);
        lock_taken[idx] = 1'b1;
      end
    end else if (r.word_offset >= MboxBase && r.word_offset < MboxBase + MailboxDepth) begin
      idx = int'(r.word_offset - MboxBase);
      if (wr) mbox_mem[idx] = r.write_data;
      else rsp.read_data = mbox_mem[idx];
    end else if (r.word_offset >= IrqBase && r.word_offset <= IrqLast) begin
      sel = irq_reg_e'(4'(r.word_offset - IrqBase));
      case (sel)
        IRQ_RAW: begin
          if (!wr) rsp.read_data = raw_lines;
        end
        IRQ_SET: begin
          if (wr) raw_lines = raw_lines | (r.write_data & LineMask);
        end
        IRQ_CLR: begin
          if (wr) raw_lines = raw_lines & ~r.write_data;
        end
        IRQ_RISC_MASK: begin
          if (wr) risc_mask = r.write_data;
          else rsp.read_data = risc_mask;
        end
        IRQ_DSP_MASK: begin
          if (wr) dsp_mask = r.write_data;
          else rsp.read_data = dsp_mask;
        end
        IRQ_MCU_MASK: begin
          if (wr) mcu_mask = r.write_data;
          else rsp.read_data = mcu_mask;
        end
        IRQ_RISC_STATUS: begin
          if (!wr) rsp.read_data = raw_lines & ~risc_mask;
        end
        IRQ_DSP_STATUS: begin
          if (!wr) rsp.read_data = raw_lines & ~dsp_mask;
        end
        default: begin
          if (!wr) rsp.read_data = raw_lines & ~mcu_mask;
        end
      endcase
    end else begin
      rsp.access_error = 1'b1;
    end
    if (wr) rsp.read_data = '0;
    rsp.mcu_irq  = |(raw_lines & ~mcu_mask);
    rsp.risc_irq = |(raw_lines & ~risc_mask);
    rsp.dsp_irq  = |(raw_lines & ~dsp_mask);
    return rsp;
  endfunction

  // offers one access, idling first at random, and records its response once taken
  task automatic send_access(input req_type_e kind, input logic [OffsetW-1:0] off,
                             input logic [DataW-1:0] data);
    imu_req_t r;
    r.req_type    = kind;
    r.word_offset = off;
    r.write_data  = data;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    awaited_rsps.push_back(apply_access(r));
  endtask

  // receiver: long hold-off when asked, random stalls otherwise
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [DataW-1:0] exp_val,
                             input logic [DataW-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    imu_rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (awaited_rsps.size() == 0) begin
        $error("response with no access outstanding: 0x%h", rsp_o);
        fail_count++;
      end else begin
        want = awaited_rsps.pop_front();
        check_field("read_data", want.read_data, rsp_o.read_data);
        check_field("access_error", DataW'(want.access_error), DataW'(rsp_o.access_error));
        check_field("mcu_irq", DataW'(want.mcu_irq), DataW'(rsp_o.mcu_irq));
        check_field("risc_irq", DataW'(want.risc_irq), DataW'(rsp_o.risc_irq));
        check_field("dsp_irq", DataW'(want.dsp_irq), DataW'(rsp_o.dsp_irq));
      end
    end
  end

  function automatic logic [DataW-1:0] random_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return DataW'(1) << $urandom_range(DataW - 1);
      default: return DataW'($urandom);
    endcase
  endfunction

  task automatic test_reset_state();
    send_access(REQ_READ, irq_off(IRQ_RAW), '0);
    send_access(REQ_READ, irq_off(IRQ_RISC_MASK), '0);
    send_access(REQ_READ, irq_off(IRQ_MCU_STATUS), '0);
    send_access(REQ_READ, irq_off(IRQ_SET), '0);
  endtask

  task automatic test_mutex();
    send_access(REQ_READ, 10'd0, '0);
    send_access(REQ_READ, 10'd0, '0);
    // non-zero write leaves the flag taken
    send_access(REQ_WRITE, 10'd0, 32'h0000_0005);
    send_access(REQ_WRITE, 10'd0, '0);
    send_access(REQ_READ, 10'd0, '0);
    send_access(REQ_READ, OffsetW'(LockCount - 1), '0);
  endtask

  task automatic test_mailbox();
    send_access(REQ_WRITE, MboxBase, '1);
    send_access(REQ_READ, MboxBase, '0);
    send_access(REQ_WRITE, MboxBase + OffsetW'(MailboxDepth - 1), 32'hA5A5_5A5A);
    send_access(REQ_READ, MboxBase + OffsetW'(MailboxDepth - 1), '0);
  endtask

  task automatic test_soft_interrupts();
    send_access(REQ_WRITE, irq_off(IRQ_MCU_MASK), '0);
    send_access(REQ_WRITE, irq_off(IRQ_SET), 32'h8000_0001);
    // raw and status words ignore writes
    send_access(REQ_WRITE, irq_off(IRQ_RAW), '1);
    send_access(REQ_WRITE, irq_off(IRQ_DSP_STATUS), '1);
    send_access(REQ_WRITE, irq_off(IRQ_CLR), 32'h0000_0001);
    send_access(REQ_READ, irq_off(IRQ_CLR), '0);
  endtask

  task automatic test_unmapped();
    send_access(REQ_READ, OffsetW'(LockCount), '0);
    send_access(REQ_WRITE, '1, '1);
    send_access(REQ_READ, IrqLast + 10'd1, '0);
  endtask

  function automatic logic [OffsetW-1:0] random_offset();
    logic [OffsetW-1:0] off;
    case ($urandom_range(19))
      0, 1, 2, 3: off = OffsetW'($urandom_range(LockCount - 1));
      4, 5, 6, 7, 8, 9: off = MboxBase + OffsetW'($urandom_range(MailboxDepth - 1));
      10, 11, 12, 13, 14, 15, 16: off = IrqBase + OffsetW'($urandom_range(IRQ_MCU_STATUS));
      default: begin
        do off = OffsetW'($urandom); while (is_mapped(off));
      end
    endcase
    return off;
  endfunction

  // one core hands a message to another: lock, fill, signal, read back, acknowledge, unlock
  task automatic send_handoff();
    logic [OffsetW-1:0] lock_off;
    logic [OffsetW-1:0] box_off;
    logic [DataW-1:0]   line;
    lock_off = OffsetW'($urandom_range(LockCount - 1));
    box_off  = MboxBase + OffsetW'($urandom_range(MailboxDepth - 1));
    line     = DataW'(1) << $urandom_range(LineCount - 1);
    send_access(REQ_READ, lock_off, '0);
    send_access(REQ_WRITE, box_off, random_word());
    send_access(REQ_WRITE, irq_off(IRQ_SET), line);
    send_access(REQ_READ, irq_off(irq_reg_e'(IRQ_RISC_STATUS + $urandom_range(2))), '0);
    send_access(REQ_READ, box_off, '0);
    send_access(REQ_WRITE, irq_off(IRQ_CLR), line);
    send_access(REQ_WRITE, lock_off, '0);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    logic [OffsetW-1:0] off;
    logic [DataW-1:0]   data;
    int                 sent;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        send_handoff();
        sent += 7;
      end else begin
        off  = random_offset();
        data = random_word();
        // mutex writes mostly release
        if (off < LockCount && $urandom_range(1) == 0) data = '0;
        send_access($urandom_range(1) ? REQ_WRITE : REQ_READ, off, data);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_len = 300;
    hold_seq++;
    repeat (40) send_access($urandom_range(1) ? REQ_WRITE : REQ_READ, random_offset(),
                            random_word());
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_mutex();
    test_mailbox();
    test_soft_interrupts();
    test_unmapped();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 58, 0);
    test_random_traffic(400, 0, 58);
    test_random_traffic(400, 16, 16);
    test_backpressure();
    req_valid_i <= 1'b0;
    rsp_stall_pct = 0;
    for (waited = 0; waited < 5000 && awaited_rsps.size() != 0; waited++) @(posedge clk_i);
    if (awaited_rsps.size() != 0) begin
      $error("%0d responses never arrived", awaited_rsps.size());
      fail_count++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(200_000 * 12);
    $error("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== intercore_mailbox_interrupt_unit.f =====
+incdir+src
src/imu_pkg.sv
src/intercore_mailbox_interrupt_unit.sv
bench/tb_intercore_mailbox_interrupt_unit.sv
